### rtl/encs_pkg.sv
`timescale 1ns / 1ps

package encs_pkg;

    // Element width (signed, Q16.16 format)
    localparam int VALUE_BITS  = 32;
    // Threshold width (unsigned, one bit narrower than an element)
    localparam int THRESH_BITS = VALUE_BITS - 1;
    // Fixed result widths
    localparam int SHRUNK_BITS = 32;
    localparam int SUM_BITS    = 64;
    // Width of the squared magnitude
    localparam int SQ_BITS     = 2 * VALUE_BITS;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};

    // Input transaction
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         is_bias;
        logic                         last;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic signed [SHRUNK_BITS-1:0] shrunk;
        logic                          bias_out;
        logic                          done_res;
        logic signed [SUM_BITS-1:0]    conjugate;
        logic                          saturated;
    } result_t;

    // After the shrink stage
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] w;
        logic [VALUE_BITS-1:0]        aw;
        logic                         is_bias;
        logic                         last;
    } shrink_t;

    // After the square stage
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] w;
        logic [SQ_BITS-1:0]           sq;
        logic                         is_bias;
        logic                         last;
    } square_t;

endpackage

### rtl/encs_shrink.sv
`timescale 1ns / 1ps

module encs_shrink
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [encs_pkg::THRESH_BITS-1:0]   threshold,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  encs_pkg::item_t                    item,
    output logic                               stage_valid,
    input  logic                               stage_ready,
    output encs_pkg::shrink_t                  stage
);

    localparam int DW = encs_pkg::VALUE_BITS + 1;

    logic                 valid_reg;
    encs_pkg::shrink_t    data_reg;
    encs_pkg::shrink_t    data_next;
    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] t_ext;
    logic signed [DW-1:0] d_minus;
    logic signed [DW-1:0] d_plus;
    logic signed [DW-1:0] w_ext;
    logic signed [DW-1:0] w_neg;

    assign item_ready = !valid_reg || stage_ready;

    // Soft threshold: x - t above t, x + t below -t, zero in between
    always_comb
    begin
        x_ext   = DW'(item.value);
        t_ext   = DW'({2'b00, threshold});
        d_minus = x_ext - t_ext;
        d_plus  = x_ext + t_ext;
        if (d_minus > 0)
        begin
            w_ext = d_minus;
        end
        else if (d_plus < 0)
        begin
            w_ext = d_plus;
        end
        else
        begin
            w_ext = '0;
        end
        w_neg             = -w_ext;
        data_next.w       = w_ext[encs_pkg::VALUE_BITS-1:0];
        data_next.aw      = w_ext[DW-1] ? w_neg[encs_pkg::VALUE_BITS-1:0]
                                        : w_ext[encs_pkg::VALUE_BITS-1:0];
        data_next.is_bias = item.is_bias;
        data_next.last    = item.last;
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = data_reg;

endmodule

### rtl/encs_square.sv
`timescale 1ns / 1ps

module encs_square
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  encs_pkg::shrink_t   src,
    output logic                dst_valid,
    input  logic                dst_ready,
    output encs_pkg::square_t   dst
);

    logic                valid_reg;
    encs_pkg::square_t   data_reg;
    encs_pkg::square_t   data_next;

    assign src_ready = !valid_reg || dst_ready;

    // Square of the shrunk magnitude
    always_comb
    begin
        data_next.w       = src.w;
        data_next.sq      = encs_pkg::SQ_BITS'(src.aw) * encs_pkg::SQ_BITS'(src.aw);
        data_next.is_bias = src.is_bias;
        data_next.last    = src.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst       = data_reg;

endmodule

### rtl/encs_accum.sv
`timescale 1ns / 1ps

module encs_accum
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  encs_pkg::square_t   src,
    output logic                result_valid,
    input  logic                result_ready,
    output encs_pkg::result_t   result
);

    localparam int SW = encs_pkg::SUM_BITS;
    localparam int EW = SW + 1;

    logic                  valid_reg;
    encs_pkg::result_t     result_reg;
    encs_pkg::result_t     result_next;
    logic signed [SW-1:0]  sum_reg;
    logic signed [SW-1:0]  sum_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic                  load;
    logic signed [EW-1:0]  ext;
    logic                  overflow;
    logic signed [SW-1:0]  acc;
    logic                  sat_now;

    assign src_ready = !valid_reg || result_ready;
    assign load      = src_valid && src_ready;

    // Contribution is ceil(w*w/2): half the square, carry in the dropped bit
    always_comb
    begin
        ext = {sum_reg[SW-1], sum_reg}
            + EW'(src.sq[encs_pkg::SQ_BITS-1:1])
            + EW'(src.sq[0]);
        // Contribution is never negative, so only the upper limit is reachable
        overflow = (ext[EW-1] != ext[EW-2]);
        acc      = overflow ? encs_pkg::SUM_MAX : ext[SW-1:0];
        sat_now  = sat_reg || overflow;

        result_next.shrunk    = encs_pkg::SHRUNK_BITS'(src.w);
        result_next.bias_out  = src.is_bias;
        result_next.done_res  = src.last;
        result_next.conjugate = src.last ? acc : '0;
        result_next.saturated = sat_now;

        sum_next = src.last ? '0 : acc;
        sat_next = src.last ? 1'b0 : sat_now;
    end

    // Running sum, saturation flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            if (src_ready)
            begin
                valid_reg <= src_valid;
            end
            if (load)
            begin
                sum_reg <= sum_next;
                sat_reg <= sat_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

### rtl/elastic_net_conjugate_shrink_unit.sv
`timescale 1ns / 1ps

// Elastic-net soft threshold with conjugate accumulation. Each element
// transaction yields one result: the element shrunk toward zero by the
// threshold, plus a running sum of ceil(w*w/2) that is returned as the
// conjugate value (Q32.32, saturating, with a sticky flag) on the element
// marked last, after which the sum restarts. The unit takes one element per
// clock while the output is not stalled; each result passes through three
// register stages (shrink, square multiplier, accumulate/output).
// The threshold register resets to zero and may only be written while no
// transaction is in flight.

module elastic_net_conjugate_shrink_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [encs_pkg::THRESH_BITS-1:0]   cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  encs_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output encs_pkg::result_t                  result
);

    logic [encs_pkg::THRESH_BITS-1:0] threshold_reg;
    logic                             shrink_valid;
    logic                             shrink_ready;
    encs_pkg::shrink_t                shrink_data;
    logic                             square_valid;
    logic                             square_ready;
    encs_pkg::square_t                square_data;

    // Threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    encs_shrink u_shrink
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .threshold   (threshold_reg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .stage_valid (shrink_valid),
        .stage_ready (shrink_ready),
        .stage       (shrink_data)
    );

    encs_square u_square
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (shrink_valid),
        .src_ready (shrink_ready),
        .src       (shrink_data),
        .dst_valid (square_valid),
        .dst_ready (square_ready),
        .dst       (square_data)
    );

    encs_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (square_valid),
        .src_ready    (square_ready),
        .src          (square_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef logic signed [encs_pkg::VALUE_BITS-1:0] val_t;
    typedef logic [encs_pkg::THRESH_BITS-1:0]       thresh_t;

    localparam val_t    VAL_MAX        = {1'b0, {(encs_pkg::VALUE_BITS-1){1'b1}}};
    localparam val_t    VAL_MIN        = {1'b1, {(encs_pkg::VALUE_BITS-1){1'b0}}};
    localparam thresh_t THRESH_MAX     = '1;
    localparam thresh_t THRESH_ONE     = 31'h0001_0000;
    localparam longint  SUM_HI         = encs_pkg::SUM_MAX;
    localparam longint  SUM_LO         = -SUM_HI - 1;
    localparam int      DRAIN_CYCLES   = 8;
    localparam int      STALL_CYCLES   = 80;
    localparam int      RANDOM_PHASES  = 8;
    localparam int      PHASE_ELEMENTS = 57;

    // DUT ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    thresh_t           cfg_data = '0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    encs_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    encs_pkg::result_t result;

    // Predictor state
    longint            conj_sum = 0;
    bit                conj_sat = 1'b0;
    thresh_t           shrink_threshold = '0;
    encs_pkg::result_t expected_results[$];

    // Traffic control
    bit idle_enable   = 1'b1;
    bit stall_request = 1'b0;
    bit stall_armed   = 1'b0;
    int hold_left     = 0;

    // Run statistics
    int mismatch_count     = 0;
    int elements_sent      = 0;
    int results_checked    = 0;
    int sets_closed        = 0;
    int saturated_sets     = 0;
    int thresholds_written = 0;

    elastic_net_conjugate_shrink_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Soft threshold of one element, then saturating accumulation of
    // x*w - t*|w| - floor(w*w/2); the set closes on last.
    function automatic encs_pkg::result_t shrink_and_accumulate(encs_pkg::item_t it);
        encs_pkg::result_t r;
        longint            x, t, w, aw, dot, l1, sq, term;
        x = longint'($signed(it.value));
        t = longint'(shrink_threshold);
        w = 0;
        if (x - t > 0)
            w = x - t;
        else if (x + t < 0)
            w = x + t;
        aw   = (w < 0) ? -w : w;
        dot  = x * w;
        l1   = t * aw;
        sq   = aw * aw;
        term = (dot - l1) - (sq >>> 1);
        if (term > 0 && conj_sum > SUM_HI - term)
        begin
            conj_sum = SUM_HI;
            conj_sat = 1'b1;
        end
        else if (term < 0 && conj_sum < SUM_LO - term)
        begin
            conj_sum = SUM_LO;
            conj_sat = 1'b1;
        end
        else
        begin
            conj_sum = conj_sum + term;
        end
        r.shrunk    = w[encs_pkg::SHRUNK_BITS-1:0];
        r.bias_out  = it.is_bias;
        r.done_res  = it.last;
        r.conjugate = it.last ? conj_sum : 64'sd0;
        r.saturated = conj_sat;
        if (it.last)
        begin
            if (conj_sat)
                saturated_sets++;
            conj_sum = 0;
            conj_sat = 1'b0;
        end
        return r;
    endfunction

    // Receiver: random idling, plus one long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (stall_request && !stall_armed)
        begin
            result_ready <= 1'b0;
            hold_left    <= STALL_CYCLES;
            stall_armed  <= 1'b1;
        end
        else
        begin
            if (!stall_request)
                stall_armed <= 1'b0;
            result_ready <= !(idle_enable && $urandom_range(99) < 19);
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] expv,
                               input logic signed [63:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            mismatch_count++;
        end
    endtask

    // Result checker: each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        encs_pkg::result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected: %p", result);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                results_checked++;
                check_field("shrunk", 64'(exp_r.shrunk), 64'(result.shrunk));
                check_field("bias_out", 64'(exp_r.bias_out), 64'(result.bias_out));
                check_field("done_res", 64'(exp_r.done_res), 64'(result.done_res));
                check_field("conjugate", exp_r.conjugate, result.conjugate);
                check_field("saturated", 64'(exp_r.saturated), 64'(result.saturated));
            end
        end
    end

    // One element transaction; valid stays up across back-to-back sends
    task automatic send_element(input val_t v, input logic b, input logic l);
        encs_pkg::item_t it;
        it.value   = v;
        it.is_bias = b;
        it.last    = l;
        while (idle_enable && $urandom_range(99) < 19)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        expected_results.push_back(shrink_and_accumulate(it));
        elements_sent++;
        if (l)
            sets_closed++;
    endtask

    // Stop offering, wait for all results, then let the pipeline settle
    task automatic drain;
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input thresh_t val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shrink_threshold = val;
        thresholds_written++;
        cfg_valid <= 1'b0;
    endtask

    // Mix of full-range, near-threshold, small and extreme elements
    function automatic val_t pick_value();
        val_t t;
        int   off;
        t   = $signed({1'b0, shrink_threshold});
        off = int'($urandom_range(4)) - 2;
        case ($urandom_range(5))
            0, 1:    return $urandom;
            2:       return t + off;
            3:       return -t + off;
            4:       return int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
        endcase
    endfunction

    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            send_element(pick_value(), $urandom_range(99) < 15, i == len - 1);
    endtask

    // Threshold at reset is zero: elements pass through unchanged
    task automatic test_reset_threshold;
        send_element(VAL_MAX, 1'b0, 1'b0);
        send_element(VAL_MIN, 1'b0, 1'b0);
        send_element('0, 1'b1, 1'b0);
        send_element(32'sd1, 1'b1, 1'b0);
        send_element(-32'sd1, 1'b0, 1'b1);
    endtask

    // Largest threshold: almost everything shrinks to zero
    task automatic test_threshold_max;
        write_threshold(THRESH_MAX);
        send_element(VAL_MAX, 1'b0, 1'b0);
        send_element(VAL_MIN, 1'b0, 1'b0);
        send_element(VAL_MIN + 1, 1'b0, 1'b0);
        send_element('0, 1'b0, 1'b0);
        send_element(VAL_MAX, 1'b1, 1'b0);
        send_element(-32'sd1, 1'b0, 1'b1);
    endtask

    // Elements right at and just past plus/minus the threshold
    task automatic test_shrink_edges;
        write_threshold(THRESH_ONE);
        send_element(32'sh0001_0000, 1'b0, 1'b0);
        send_element(32'sh0001_0001, 1'b0, 1'b0);
        send_element(-32'sh0001_0000, 1'b0, 1'b0);
        send_element(-32'sh0001_0001, 1'b0, 1'b0);
        send_element(32'sh0003_8000, 1'b1, 1'b0);
        send_element(-32'sh0002_4000, 1'b0, 1'b1);
    endtask

    // Sum clips at the top, flag sticks to the end of the set, then clears
    task automatic test_sum_saturation;
        write_threshold('0);
        repeat (4) send_element(VAL_MIN, 1'b0, 1'b0);
        send_element(32'sd1, 1'b1, 1'b0);
        send_element(VAL_MIN, 1'b0, 1'b1);
        send_element(32'sd3, 1'b0, 1'b0);
        send_element(VAL_MAX, 1'b1, 1'b1);
    endtask

    // Receiver holds off while elements keep coming, so the input stalls
    task automatic test_output_backpressure;
        write_threshold(thresh_t'($urandom_range(32'h0004_0000)));
        stall_request <= 1'b1;
        repeat (5) send_random_set($urandom_range(1, 10));
        stall_request <= 1'b0;
        drain();
    endtask

    // Random sets over several thresholds, one phase without idling
    task automatic test_random_streams;
        int      start;
        thresh_t thr;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       thr = '0;
                1:       thr = THRESH_MAX;
                2, 5:    thr = thresh_t'($urandom_range(32'h0004_0000));
                default: thr = thresh_t'($urandom);
            endcase
            write_threshold(thr);
            idle_enable = (p != 3);
            start = elements_sent;
            while (elements_sent - start < PHASE_ELEMENTS)
                send_random_set($urandom_range(1, 10));
        end
        idle_enable = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_threshold();
        test_threshold_max();
        test_shrink_edges();
        test_sum_saturation();
        test_output_backpressure();
        test_random_streams();
        drain();
        $display("Run covered %0d elements in %0d sets (%0d saturated), %0d results checked,",
                 elements_sent, sets_closed, saturated_sets, results_checked);
        $display("%0d threshold writes, a long output hold-off and a stretch without idling.",
                 thresholds_written);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/encs_pkg.sv
rtl/encs_shrink.sv
rtl/encs_square.sv
rtl/encs_accum.sv
rtl/elastic_net_conjugate_shrink_unit.sv
dv/tb_top.sv
